>>> src/pee_pkg.sv
// ============================================================================
// pee_pkg - shared types and constants of the postfix expression evaluator
// Character codes, status codes, command format and state encodings.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pee_pkg;

  // ASCII codes of interest
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_BAD_OP    = 3'd3,
    ST_DIV_ZERO  = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  // one queue entry: optional push, optional operator, end marker
  typedef struct packed {
    logic       push;
    logic       op;
    logic [7:0] op_char;
    logic       last;
  } cmd_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_REM,
    ALU_POW
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DISPATCH,
    BK_READ,
    BK_ALU,
    BK_RELOAD,
    BK_END
  } back_state_t;

  typedef enum logic [2:0] {
    AL_IDLE,
    AL_MUL,
    AL_DIV,
    AL_POW_CHK,
    AL_POW_ACC,
    AL_POW_SQ,
    AL_DONE
  } alu_state_t;

endpackage

`default_nettype wire

>>> src/pee_if.sv
// ============================================================================
// pee_if - request channels of the postfix expression evaluator
// Character channel in, result channel out; valid/ready handshake.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface pee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       expr_end;
  modport source (output valid, char_code, expr_end, input ready);
  modport sink   (input valid, char_code, expr_end, output ready);
endinterface

interface pee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [2:0]         status;
  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

`default_nettype wire

>>> src/postfix_expression_evaluator.sv
// ============================================================================
// postfix_expression_evaluator - reverse Polish evaluator, one char a request
// Top level: classifier, command queue and stack machine.
// ============================================================================
// Characters arrive one per request on in_chan; expr_end marks the last one.
// Digit runs build a number (wrapping at VALUE_WIDTH bits) that is pushed at
// the next non-digit or at the end; space, tab and NUL are skipped; + - * / %
// and $ (integer power) pop two values and push the result. At the end one
// request on out_chan carries the top of stack, sign-extended or cut to 32
// bits, with status 0, or value 0 with status 1 (empty stack), 2 (underflow),
// 3 (bad operator), 4 (divide by zero) or 5 (overflow; the push is dropped).
// The first error of an expression is kept. The classifier takes a character
// each cycle while its two-entry queue has room; the stack machine then
// fetches each command and does its push and its operator in turn: + and -
// in the stack machine itself, * / % and $ in the serial arithmetic unit,
// whose shift-add multiplier stops when the multiplier runs out of ones and
// whose power takes one squaring per exponent bit and one multiply per set
// bit. An expression ends once the result register is free. The stack lives
// in a RAM of STACK_DEPTH words with the top held in a register; no clearing
// pass.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  pee_in_if.sink   in_chan,
  pee_out_if.source out_chan
);
  import pee_pkg::*;

  localparam int QW = $bits(cmd_t) + VALUE_WIDTH;

  // front to queue
  logic                   fq_wr;
  cmd_t                   fq_cmd;
  logic [VALUE_WIDTH-1:0] fq_value;
  logic                   q_full;
  // queue to back
  logic                   q_rd;
  logic                   q_empty;
  logic [QW-1:0]          q_data;
  cmd_t                   bq_cmd;
  logic [VALUE_WIDTH-1:0] bq_value;

  assign bq_cmd   = q_data[QW-1 -: $bits(cmd_t)];
  assign bq_value = q_data[VALUE_WIDTH-1:0];

  pee_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .char_code (in_chan.char_code),
    .expr_end  (in_chan.expr_end),
    .q_full    (q_full),
    .q_wr      (fq_wr),
    .q_cmd     (fq_cmd),
    .q_value   (fq_value)
  );

  // one entry per character that needs stack work
  pee_fifo #(.DATA_W(QW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_wr),
    .wr_data ({fq_cmd, fq_value}),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  pee_back #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (bq_cmd),
    .q_value    (bq_value),
    .q_rd       (q_rd),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_value  (out_chan.result_value),
    .out_status (out_chan.status)
  );

endmodule

`default_nettype wire

>>> src/pee_ram.sv
// ============================================================================
// pee_ram - generic single write, single read RAM
// One write port, one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/pee_front.sv
// ============================================================================
// pee_front - character classifier
// Builds numbers from digit runs and queues push/operator/end commands.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pee_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             char_code,
  input  wire logic                   expr_end,
  input  wire logic                   q_full,
  output logic                        q_wr,
  output pee_pkg::cmd_t               q_cmd,
  output logic [VALUE_WIDTH-1:0]      q_value
);
  import pee_pkg::*;

  logic [VALUE_WIDTH-1:0] accum_r;
  logic                   in_num_r;
  logic                   accept;
  logic                   digit;
  logic                   skip;
  logic [VALUE_WIDTH-1:0] accum_new;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign digit     = (char_code >= CH_0) && (char_code <= CH_9);
  assign skip      = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                     (char_code == CH_NUL);
  // x*10 as two shifts; low nibble of '0'..'9' is the digit
  assign accum_new = (accum_r << 3) + (accum_r << 1) + VALUE_WIDTH'(char_code[3:0]);

  always_comb begin
    q_cmd.op_char = char_code;
    q_cmd.last    = expr_end;
    if (digit) begin
      q_cmd.push = expr_end;
      q_cmd.op   = 1'b0;
      q_value    = accum_new;
    end else begin
      q_cmd.push = in_num_r;
      q_cmd.op   = !skip;
      q_value    = accum_r;
    end
    q_wr = accept && (q_cmd.push || q_cmd.op || q_cmd.last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r  <= '0;
      in_num_r <= 1'b0;
    end else if (accept) begin
      if (digit && !expr_end) begin
        accum_r  <= accum_new;
        in_num_r <= 1'b1;
      end else begin
        accum_r  <= '0;
        in_num_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/pee_fifo.sv
// ============================================================================
// pee_fifo - two-entry command queue
// Decouples the classifier from the stack machine.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pee_fifo #(
  parameter int DATA_W = 43
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   full,
  input  wire logic              rd_en,
  output logic      [DATA_W-1:0] rd_data,
  output logic                   empty
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  logic [DATA_W-1:0] mem_r [Depth];
  logic [PtrW-1:0]   wptr_r;
  logic [PtrW-1:0]   rptr_r;
  logic [CntW-1:0]   cnt_r;
  logic              do_wr;
  logic              do_rd;

  assign full    = (cnt_r == CntW'(Depth));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) wptr_r <= wptr_r + PtrW'(1);
      if (do_rd) rptr_r <= rptr_r + PtrW'(1);
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + CntW'(1);
        2'b01:   cnt_r <= cnt_r - CntW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/pee_alu.sv
// ============================================================================
// pee_alu - iterative multiply, divide, remainder and power unit
// Shift-add multiplier, restoring divider, square-and-multiply power.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pee_alu #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pee_pkg::alu_req_t      req,
  input  wire logic [VALUE_WIDTH-1:0] lhs,
  input  wire logic [VALUE_WIDTH-1:0] rhs,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      result
);
  import pee_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int DW = $clog2(W + 1);

  alu_state_t      state_r, state_nxt;
  alu_op_t         op_r;
  logic [W-1:0]    mcand_r, mplier_r, prod_r;
  logic [W-1:0]    base_r, ex_r, acc_r;
  logic [W-1:0]    quo_r, rem_r, dsr_r;
  logic [DW-1:0]   dcnt_r;
  logic            neg_r;
  logic [W-1:0]    res_r;
  logic            mul_busy;
  logic [W-1:0]    prod_step;
  logic [W:0]      dtrial;
  logic            dge;
  logic [W-1:0]    dmag;

  assign mul_busy  = (mplier_r != '0);
  assign prod_step = prod_r + (mplier_r[0] ? mcand_r : '0);
  assign dtrial    = {rem_r, quo_r[W-1]};
  assign dge       = (dtrial >= {1'b0, dsr_r});
  assign dmag      = (op_r == ALU_DIV) ? quo_r : rem_r;
  assign done      = (state_r == AL_DONE);
  assign result    = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      AL_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            ALU_MUL:          state_nxt = AL_MUL;
            ALU_DIV, ALU_REM: state_nxt = AL_DIV;
            ALU_POW:          state_nxt = rhs[W-1] ? AL_DONE : AL_POW_CHK;
            default:          state_nxt = AL_IDLE;
          endcase
        end
      end
      AL_MUL:     if (!mul_busy) state_nxt = AL_DONE;
      AL_DIV:     if (dcnt_r == '0) state_nxt = AL_DONE;
      AL_POW_CHK: begin
        if (ex_r == '0)   state_nxt = AL_DONE;
        else if (ex_r[0]) state_nxt = AL_POW_ACC;
        else              state_nxt = AL_POW_SQ;
      end
      AL_POW_ACC: if (!mul_busy) state_nxt = AL_POW_SQ;
      AL_POW_SQ:  if (!mul_busy) state_nxt = AL_POW_CHK;
      AL_DONE:    state_nxt = AL_IDLE;
      default:    state_nxt = AL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      AL_IDLE: begin
        op_r <= req.op;
        if (req.start) begin
          case (req.op)
            ALU_MUL: begin
              mcand_r  <= lhs;
              mplier_r <= rhs;
              prod_r   <= '0;
            end
            ALU_POW: begin
              base_r <= lhs;
              ex_r   <= rhs;
              acc_r  <= W'(1);
              // negative exponent: only bases of one and minus one survive
              if (lhs == W'(1))    res_r <= W'(1);
              else if (&lhs)       res_r <= rhs[0] ? '1 : W'(1);
              else                 res_r <= '0;
            end
            default: begin
              quo_r  <= lhs[W-1] ? -lhs : lhs;
              dsr_r  <= rhs[W-1] ? -rhs : rhs;
              rem_r  <= '0;
              dcnt_r <= DW'(W);
              neg_r  <= (req.op == ALU_DIV) ? (lhs[W-1] ^ rhs[W-1]) : lhs[W-1];
            end
          endcase
        end
      end
      AL_MUL, AL_POW_ACC, AL_POW_SQ: begin
        if (mul_busy) begin
          prod_r   <= prod_step;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
        end else if (state_r == AL_MUL) begin
          res_r <= prod_r;
        end else if (state_r == AL_POW_ACC) begin
          acc_r    <= prod_r;
          mcand_r  <= base_r;
          mplier_r <= base_r;
          prod_r   <= '0;
        end else begin
          base_r <= prod_r;
          ex_r   <= ex_r >> 1;
        end
      end
      AL_POW_CHK: begin
        if (ex_r == '0) begin
          res_r <= acc_r;
        end else begin
          mcand_r  <= ex_r[0] ? acc_r : base_r;
          mplier_r <= base_r;
          prod_r   <= '0;
        end
      end
      AL_DIV: begin
        if (dcnt_r != '0) begin
          rem_r  <= dge ? W'(dtrial - {1'b0, dsr_r}) : dtrial[W-1:0];
          quo_r  <= {quo_r[W-2:0], dge};
          dcnt_r <= dcnt_r - DW'(1);
        end else begin
          res_r <= neg_r ? -dmag : dmag;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/pee_back.sv
// ============================================================================
// pee_back - stack machine
// Executes queued commands against the value stack and forms the result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pee_back #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_empty,
  input  wire pee_pkg::cmd_t          q_cmd,
  input  wire logic [VALUE_WIDTH-1:0] q_value,
  output logic                        q_rd,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [31:0]          out_value,
  output logic [2:0]                  out_status
);
  import pee_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  back_state_t   state_r, state_nxt;
  logic          push_pend_r, op_pend_r, end_pend_r;
  logic [7:0]    op_char_r;
  logic [W-1:0]  push_val_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  top_r;
  status_t       err_r;
  logic          out_valid_r;
  logic [31:0]   out_value_r;
  status_t       out_status_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [W-1:0]  ram_rdata;
  alu_req_t      alu_req;
  logic          alu_done;
  logic [W-1:0]  alu_res;
  logic          stk_full, short_stk, div_op, div_zero, simple_op, alu_op, need_reload;
  logic          out_free;
  logic [W-1:0]  simple_res;

  function automatic status_t sticky(status_t cur, status_t code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  assign stk_full    = (cnt_r == CW'(STACK_DEPTH));
  assign short_stk   = (cnt_r < CW'(2));
  assign div_op      = (op_char_r == CH_SLASH) || (op_char_r == CH_PCT);
  assign div_zero    = div_op && (top_r == '0);
  assign simple_op   = (op_char_r == CH_PLUS) || (op_char_r == CH_MINUS);
  assign alu_op      = (op_char_r == CH_STAR) || (op_char_r == CH_DOLLAR) ||
                       (div_op && !div_zero);
  assign need_reload = (cnt_r > CW'(2));
  assign simple_res  = (op_char_r == CH_PLUS) ? ram_rdata + top_r : ram_rdata - top_r;
  assign out_free    = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  pee_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (top_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pee_alu #(.VALUE_WIDTH(W)) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .lhs    (ram_rdata),
    .rhs    (top_r),
    .done   (alu_done),
    .result (alu_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:     if (!q_empty) state_nxt = BK_DISPATCH;
      BK_DISPATCH: begin
        if (push_pend_r)     state_nxt = BK_DISPATCH;
        else if (op_pend_r)  state_nxt = short_stk ? BK_DISPATCH : BK_READ;
        else if (end_pend_r) state_nxt = BK_END;
        else                 state_nxt = BK_IDLE;
      end
      BK_READ: begin
        if (simple_op)        state_nxt = BK_DISPATCH;
        else if (alu_op)      state_nxt = BK_ALU;
        else if (need_reload) state_nxt = BK_RELOAD;
        else                  state_nxt = BK_DISPATCH;
      end
      BK_ALU:    if (alu_done) state_nxt = BK_DISPATCH;
      BK_RELOAD: state_nxt = BK_DISPATCH;
      BK_END:    if (out_free) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_rd      = (state_r == BK_IDLE) && !q_empty;
    ram_we    = (state_r == BK_DISPATCH) && push_pend_r && (cnt_r != '0) && !stk_full;
    ram_waddr = AW'(cnt_r - CW'(1));
    ram_raddr = (state_r == BK_DISPATCH) ? AW'(cnt_r - CW'(2)) : AW'(cnt_r - CW'(3));
    alu_req.start = (state_r == BK_READ) && alu_op;
    unique case (op_char_r)
      CH_STAR:  alu_req.op = ALU_MUL;
      CH_SLASH: alu_req.op = ALU_DIV;
      CH_PCT:   alu_req.op = ALU_REM;
      default:  alu_req.op = ALU_POW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      push_pend_r <= 1'b0;
      op_pend_r   <= 1'b0;
      end_pend_r  <= 1'b0;
      cnt_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // the end state reloads the result register itself
      if (out_valid_r && out_ready && state_r != BK_END) out_valid_r <= 1'b0;
      case (state_r)
        BK_IDLE: begin
          if (!q_empty) begin
            push_pend_r <= q_cmd.push;
            op_pend_r   <= q_cmd.op;
            end_pend_r  <= q_cmd.last;
            op_char_r   <= q_cmd.op_char;
            push_val_r  <= q_value;
          end
        end
        BK_DISPATCH: begin
          if (push_pend_r) begin
            push_pend_r <= 1'b0;
            if (stk_full) begin
              err_r <= sticky(err_r, ST_OVERFLOW);
            end else begin
              top_r <= push_val_r;
              cnt_r <= cnt_r + CW'(1);
            end
          end else if (op_pend_r) begin
            op_pend_r <= 1'b0;
            if (short_stk) err_r <= sticky(err_r, ST_UNDERFLOW);
          end
        end
        BK_READ: begin
          if (simple_op) begin
            top_r <= simple_res;
            cnt_r <= cnt_r - CW'(1);
          end else if (alu_op) begin
            cnt_r <= cnt_r - CW'(1);
          end else begin
            cnt_r <= cnt_r - CW'(2);
            err_r <= sticky(err_r, div_zero ? ST_DIV_ZERO : ST_BAD_OP);
          end
        end
        BK_ALU: begin
          if (alu_done) top_r <= alu_res;
        end
        BK_RELOAD: top_r <= ram_rdata;
        BK_END: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (err_r != ST_OK) begin
              out_value_r  <= '0;
              out_status_r <= err_r;
            end else if (cnt_r == '0) begin
              out_value_r  <= '0;
              out_status_r <= ST_EMPTY;
            end else begin
              out_value_r  <= 32'($signed(top_r));
              out_status_r <= ST_OK;
            end
            cnt_r      <= '0;
            err_r      <= ST_OK;
            end_pend_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_read_two: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_READ) |-> (cnt_r >= CW'(2))) else $error("operator with short stack");
  a_alu_owner: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> (state_r == BK_ALU)) else $error("arithmetic result unclaimed");
  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_END && out_free) |=> (cnt_r == '0 && out_valid_r))
    else $error("expression end did not clear stack");

endmodule

`default_nettype wire

>>> verif/postfix_expression_evaluator_tb.sv
// ============================================================================
// postfix_expression_evaluator_tb - self-checking bench of the RPN evaluator
// Feeds character streams (directed cases, then random well-formed and broken
// expressions) with random idling on both channels. Predicts each result
// in a small scoreboard class and compares it field by field.
// ============================================================================
`timescale 1ns / 1ps

module postfix_expression_evaluator_tb;
  import pee_pkg::*;

  localparam int DEPTH      = 64;
  localparam int IDLE_LIMIT = 20000;  // a long power op plus a long hold-off
  localparam int N_CHARS    = 1450;

  typedef struct {
    logic signed [31:0] value;
    status_t            st;
  } rpn_result_t;

  // Predicts the evaluator and holds the results still to come out.
  class rpn_scoreboard;
    logic [31:0]  stk[DEPTH];
    int unsigned  cnt;
    logic [31:0]  acc;
    bit           in_num;
    status_t      err;
    rpn_result_t  due_q[$];
    int           mismatches;

    function new();
      cnt = 0; acc = '0; in_num = 0; err = ST_OK; mismatches = 0;
    endfunction

    function void flag(status_t s);
      if (err == ST_OK) err = s;
    endfunction

    function void push(logic [31:0] v);
      if (cnt >= DEPTH) begin
        flag(ST_OVERFLOW);
        return;
      end
      stk[cnt] = v;
      cnt++;
    endfunction

    function logic [31:0] power(logic [31:0] b, logic [31:0] e);
      logic [31:0] p;
      p = 32'd1;
      if (e[31]) begin
        // negative exponent: only +1 and -1 survive
        if (b == 32'd1) return 32'd1;
        if (b == '1) return e[0] ? '1 : 32'd1;
        return '0;
      end
      while (e != 0) begin
        if (e[0]) p = p * b;
        b = b * b;
        e = e >> 1;
      end
      return p;
    endfunction

    function void apply_op(logic [7:0] c);
      logic [31:0] rhs, lhs, r, ma, mb;
      if (cnt < 2) begin
        flag(ST_UNDERFLOW);
        return;
      end
      rhs = stk[cnt-1];
      lhs = stk[cnt-2];
      cnt -= 2;
      case (c)
        CH_PLUS:   r = lhs + rhs;
        CH_MINUS:  r = lhs - rhs;
        CH_STAR:   r = lhs * rhs;
        CH_DOLLAR: r = power(lhs, rhs);
        CH_SLASH, CH_PCT: begin
          if (rhs == 0) begin
            flag(ST_DIV_ZERO);
            return;
          end
          // unsigned magnitudes; the most negative value maps to itself
          ma = lhs[31] ? -lhs : lhs;
          mb = rhs[31] ? -rhs : rhs;
          if (c == CH_SLASH) begin
            r = ma / mb;
            if (lhs[31] != rhs[31]) r = -r;
          end else begin
            r = ma % mb;
            if (lhs[31]) r = -r;
          end
        end
        default: begin
          flag(ST_BAD_OP);
          return;
        end
      endcase
      push(r);
    endfunction

    // note an accepted request
    function void note_char(logic [7:0] c, bit last);
      rpn_result_t res;
      if (c >= CH_0 && c <= CH_9) begin
        acc = acc * 32'd10 + 32'(c - CH_0);
        in_num = 1;
      end else begin
        if (in_num) begin
          push(acc);
          acc = '0;
          in_num = 0;
        end
        if (c != CH_SPACE && c != CH_TAB && c != CH_NUL) apply_op(c);
      end
      if (!last) return;
      if (in_num) push(acc);
      if (err != ST_OK) begin
        res.value = '0; res.st = err;
      end else if (cnt == 0) begin
        res.value = '0; res.st = ST_EMPTY;
      end else begin
        res.value = stk[cnt-1]; res.st = ST_OK;
      end
      due_q.push_back(res);
      cnt = 0; acc = '0; in_num = 0; err = ST_OK;
    endfunction

    function void check_result(logic signed [31:0] v, logic [2:0] s);
      rpn_result_t e;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result value=%0d status=%0d", $realtime, v, s);
        return;
      end
      e = due_q.pop_front();
      if (v !== e.value || s !== e.st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result mismatch exp value=%0d status=%0d, got value=%0d status=%0d",
                   $realtime, e.value, e.st, v, s);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pee_in_if  in_chan();
  pee_out_if out_chan();

  postfix_expression_evaluator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always #5 clk = ~clk;

  rpn_scoreboard sb = new();
  bit quiet    = 0;   // last part of the run: no idling
  bit hold_req = 0;   // ask the receiver for a long hold-off
  int sent     = 0;

  initial begin
    in_chan.valid     = 1'b0;
    in_chan.char_code = '0;
    in_chan.expr_end  = 1'b0;
    out_chan.ready    = 1'b0;
  end

  // one request; valid is left high for the next one
  task automatic send_char(logic [7:0] c, bit last);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.char_code <= c;
    in_chan.expr_end  <= last;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_char(c, last);
    sent++;
  endtask

  task automatic send_expr(logic [7:0] q[$]);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
  endtask

  task automatic send_text(string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_expr(q);
  endtask

  task automatic add_number(inout logic [7:0] q[$]);
    int nd;
    nd = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 12);
    for (int i = 0; i < nd; i++) q.push_back(CH_0 + 8'($urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] pick_op();
    int k;
    k = $urandom_range(0, 19);
    if (k < 5)  return CH_PLUS;
    if (k < 10) return CH_MINUS;
    if (k < 14) return CH_STAR;
    if (k < 16) return CH_SLASH;
    if (k < 18) return CH_PCT;
    return CH_DOLLAR;
  endfunction

  // random well-formed expression, sometimes broken by noise or a dropped last character
  task automatic make_expr(output logic [7:0] q[$]);
    int operands, depth;
    bit noisy;
    q = {};
    depth = 0;
    operands = $urandom_range(1, 6);
    noisy = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < operands; i++) begin
      add_number(q);
      depth++;
      q.push_back($urandom_range(0, 3) == 0 ? CH_TAB : CH_SPACE);
      while (depth >= 2 && $urandom_range(0, 2) == 0) begin
        q.push_back(pick_op());
        depth--;
      end
    end
    while (depth >= 2) begin
      q.push_back(pick_op());
      depth--;
    end
    if (noisy)
      for (int i = 0; i < q.size(); i++)
        if ($urandom_range(0, 5) == 0) q[i] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) void'(q.pop_back());
    if (q.size() == 0) q.push_back(CH_0 + 8'($urandom_range(0, 9)));
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // receiver: checks results and stalls in bursts
  initial begin
    @(posedge rst_n);
    out_chan.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready)
        sb.check_result(out_chan.result_value, out_chan.status);
      if (hold_req) begin
        // long hold-off so the block fills up and stalls its input
        hold_req = 0;
        out_chan.ready <= 1'b0;
        repeat (400) @(posedge clk);
        out_chan.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_chan.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no request accepted on either side
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] q[$];
    int n_expr;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every operator, empty stack, error cases, arithmetic corners
    send_text(" ");                       // empty stack
    send_text("3 4+");
    send_text("3\t10-");
    send_text("4294967295 2*");           // wraps
    send_text("99999999999");             // number growth wraps
    send_text("0 7-2/");                  // truncation toward zero
    send_text("0 7-2%");                  // remainder keeps left sign
    send_text("0 2147483648- 0 1-/");     // most negative / -1
    send_text("0 2147483648- 0 1-%");
    send_text("2 10$");
    send_text("5 0$");                    // zero exponent
    send_text("2 0 1-$");                 // negative exponent, other base
    send_text("1 0 5-$");
    send_text("0 1- 0 3-$");
    send_text("0 1- 0 4-$");
    send_text("+");                       // underflow
    send_text("1 2x");                    // bad operator
    send_text("x");                       // underflow beats bad operator
    send_text("1 0/");                    // divide by zero
    send_text("1 0%3 4+");                // error stays sticky
    q = {CH_0 + 8'd1, CH_NUL, CH_0 + 8'd2, CH_PLUS, 8'hFF};
    send_expr(q);
    q = {};
    for (int i = 0; i < DEPTH + 2; i++) begin
      q.push_back(CH_0 + 8'd1);
      q.push_back(CH_SPACE);
    end
    send_expr(q);                          // stack overflow

    // random part
    n_expr = 0;
    while (sent < N_CHARS) begin
      if (n_expr == 40) hold_req = 1;
      if (n_expr == 80) begin
        in_chan.valid <= 1'b0;
        wait_drained();
      end
      if (sent > N_CHARS - 250) quiet = 1;
      if ($urandom_range(0, 9) == 0) begin
        q = {};
        repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
      end else begin
        make_expr(q);
      end
      send_expr(q);
      n_expr++;
    end
    in_chan.valid <= 1'b0;

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
